/* src/spar_pkg.sv */
// spar_pkg: shared types, widths, constants and the CORDIC angle table for the
// strip position block. No dependencies.
`default_nettype none
package spar_pkg;
    localparam int ID_W          = 8;
    localparam int CH_W          = 16;
    localparam int ATAN_ITER_DEF = 16;
    localparam int FRAC          = 24;                  // angle fraction bits
    localparam int CORDIC_W      = 52;                  // CORDIC x/y datapath
    localparam int ANG_W         = 27;                  // signed Q24 angle
    localparam int NUM_W         = ANG_W + FRAC;        // divider dividend
    localparam int DEN_W         = ANG_W - 1;           // divider divisor
    localparam int CFG_W         = 16;
    localparam int OFS_W         = 24;
    localparam int POS_W         = 24;
    localparam int K_BITS        = 41;                  // |k| <= 2^40
    localparam int K_W           = K_BITS + 1;
    localparam int STRIP_SHIFT   = 25;                  // strip term is Q25
    localparam int CENTER_SHIFT  = 17;                  // Q8.8 -> Q25
    localparam int T_W           = 44;
    localparam int P_W           = T_W + CFG_W + 1;
    localparam int ADDR_W        = 5;

    localparam logic signed [ANG_W-1:0] PI4 = 27'sd13176795;
    localparam logic signed [ANG_W-1:0] PI2 = 27'sd26353589;
    localparam logic signed [CORDIC_W-1:0] ONE_Q32 = 52'sd4294967296;
    localparam logic [NUM_W-1:0] K_LIMIT = 51'd1099511627776;

    // register map, word index
    localparam logic [2:0] REG_SHAPE_B  = 3'd0;
    localparam logic [2:0] REG_CENTER   = 3'd1;
    localparam logic [2:0] REG_WIDTH    = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_TURNED   = 3'd4;

    localparam logic [CFG_W-1:0] RST_SHAPE_B = 16'd256;

    typedef struct packed {
        logic [1:0]      hit_count;
        logic [ID_W-1:0] lead_strip;
        logic [ID_W-1:0] second_strip;
        logic [ID_W-1:0] third_strip;
        logic [CH_W-1:0] lead_charge;
        logic [CH_W-1:0] second_charge;
        logic [CH_W-1:0] third_charge;
    } t_in;

    typedef struct packed {
        logic                    valid_res;
        logic [ID_W-1:0]         hit_strip;
        logic [CH_W-1:0]         hit_charge;
        logic signed [POS_W-1:0] position_mm;
    } t_out;

    // per-event bookkeeping that rides along the pipe
    typedef struct packed {
        logic            ok;
        logic            dir_pos;
        logic [ID_W-1:0] id0;
        logic [CH_W-1:0] c0;
    } t_meta;

    function automatic logic signed [ANG_W-1:0] step_angle(input int i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            0:       r = 27'sd13176795;
            1:       r = 27'sd7778716;
            2:       r = 27'sd4110060;
            3:       r = 27'sd2086331;
            4:       r = 27'sd1047214;
            5:       r = 27'sd524117;
            6:       r = 27'sd262123;
            7:       r = 27'sd131069;
            default: r = ANG_W'(1) <<< (FRAC - i);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* src/spar_front.sv */
// spar_front: event checks and CORDIC operand setup, one register stage.
// Depends on spar_pkg.
`default_nettype none
module spar_front (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  spar_pkg::t_in                        i_data,
    input  wire                                  i_b_nz,
    output logic                                 o_valid,
    output spar_pkg::t_meta                      o_meta,
    output logic                                 o_bypass,
    output logic                                 o_byp_neg,
    output logic signed [spar_pkg::CORDIC_W-1:0] o_x,
    output logic signed [spar_pkg::CORDIC_W-1:0] o_y
);
    localparam int IW = spar_pkg::ID_W;
    localparam int CW = spar_pkg::CH_W;

    logic signed [IW:0]   d;
    logic                 three, near, geo, ok;
    logic [CW-1:0]        c2;
    logic signed [CW:0]   xr, yr, xa, ya;
    spar_pkg::t_meta      meta;

    always_comb begin
        three = (i_data.hit_count == 2'd3);
        d     = $signed({1'b0, i_data.lead_strip}) - $signed({1'b0, i_data.second_strip});
        near  = (d <= 2) && (d >= -2);
        geo   = !three || (({1'b0, i_data.second_strip} + {1'b0, i_data.third_strip})
                           == {i_data.lead_strip, 1'b0});
        c2    = three ? i_data.third_charge : '0;
        xr    = $signed({1'b0, i_data.lead_charge}) - $signed({1'b0, i_data.second_charge});
        yr    = $signed({1'b0, i_data.lead_charge}) - $signed({1'b0, c2});
        ok    = (i_data.hit_count >= 2'd2) && near && geo
                && (i_data.lead_charge != '0) && i_b_nz
                && !((xr == 0) && (yr == 0));
        // keep x positive for the vectoring CORDIC
        xa    = xr[CW] ? -xr : xr;
        ya    = xr[CW] ? -yr : yr;
        meta.ok      = ok;
        meta.dir_pos = i_data.lead_strip < i_data.second_strip;
        meta.id0     = i_data.lead_strip;
        meta.c0      = i_data.lead_charge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_meta    <= meta;
            o_bypass  <= (xr == 0);
            o_byp_neg <= yr[CW];
            o_x       <= spar_pkg::CORDIC_W'(xa) <<< spar_pkg::FRAC;
            o_y       <= spar_pkg::CORDIC_W'(ya) <<< spar_pkg::FRAC;
        end
    end
endmodule
`default_nettype wire

/* src/spar_cordic.sv */
// spar_cordic: pipelined vectoring CORDIC, one rotation per stage, LANES
// independent vectors sharing a sideband. Depends on spar_pkg.
`default_nettype none
module spar_cordic #(
    parameter int ITER  = spar_pkg::ATAN_ITER_DEF,
    parameter int LANES = 1,
    parameter int SB_W  = 1
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_en,
    input  wire                                  i_valid,
    input  wire signed [spar_pkg::CORDIC_W-1:0]  i_x [LANES],
    input  wire signed [spar_pkg::CORDIC_W-1:0]  i_y [LANES],
    input  wire [SB_W-1:0]                       i_sb,
    output logic                                 o_valid,
    output logic signed [spar_pkg::ANG_W-1:0]    o_z [LANES],
    output logic [SB_W-1:0]                      o_sb
);
    localparam int CW = spar_pkg::CORDIC_W;
    localparam int ZW = spar_pkg::ANG_W;

    logic signed [CW-1:0] r_x [ITER][LANES];
    logic signed [CW-1:0] r_y [ITER][LANES];
    logic signed [ZW-1:0] r_z [ITER][LANES];
    logic [SB_W-1:0]      r_sb [ITER];
    logic [ITER-1:0]      r_v;

    for (genvar k = 0; k < ITER; k++) begin : g_st
        logic signed [CW-1:0] sx [LANES];
        logic signed [CW-1:0] sy [LANES];
        logic signed [ZW-1:0] sz [LANES];
        logic [SB_W-1:0]      ssb;
        logic                 sv;

        if (k == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    sx[l] = i_x[l];
                    sy[l] = i_y[l];
                    sz[l] = '0;
                end
                ssb = i_sb;
                sv  = i_valid;
            end
        end else begin : g_body
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    sx[l] = r_x[k-1][l];
                    sy[l] = r_y[k-1][l];
                    sz[l] = r_z[k-1][l];
                end
                ssb = r_sb[k-1];
                sv  = r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    if (!sy[l][CW-1]) begin
                        r_x[k][l] <= sx[l] + (sy[l] >>> k);
                        r_y[k][l] <= sy[l] - (sx[l] >>> k);
                        r_z[k][l] <= sz[l] + spar_pkg::step_angle(k);
                    end else begin
                        r_x[k][l] <= sx[l] - (sy[l] >>> k);
                        r_y[k][l] <= sy[l] + (sx[l] >>> k);
                        r_z[k][l] <= sz[l] - spar_pkg::step_angle(k);
                    end
                end
                r_sb[k] <= ssb;
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_z[l] = r_z[ITER-1][l];
        end
        o_sb    = r_sb[ITER-1];
        o_valid = r_v[ITER-1];
    end
endmodule
`default_nettype wire

/* src/spar_div.sv */
// spar_div: pipelined restoring unsigned divider, one quotient bit per stage.
// Depends on spar_pkg for default widths.
`default_nettype none
module spar_div #(
    parameter int NW   = spar_pkg::NUM_W,
    parameter int DW   = spar_pkg::DEN_W,
    parameter int SB_W = 1
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [NW-1:0]     i_num,
    input  wire [DW-1:0]     i_den,
    input  wire [SB_W-1:0]   i_sb,
    output logic             o_valid,
    output logic [NW-1:0]    o_q,
    output logic [SB_W-1:0]  o_sb
);
    // r_nq holds the unused dividend bits on top and the quotient bits below
    logic [NW-1:0]   r_nq  [NW];
    logic [DW-1:0]   r_rem [NW];
    logic [DW-1:0]   r_den [NW];
    logic [SB_W-1:0] r_sb  [NW];
    logic [NW-1:0]   r_v;

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic [NW-1:0]   snq;
        logic [DW-1:0]   srem, sden;
        logic [SB_W-1:0] ssb;
        logic            sv, ge;
        logic [DW:0]     tmp, dif;

        if (k == 0) begin : g_head
            always_comb begin
                snq  = i_num;
                srem = '0;
                sden = i_den;
                ssb  = i_sb;
                sv   = i_valid;
            end
        end else begin : g_body
            always_comb begin
                snq  = r_nq[k-1];
                srem = r_rem[k-1];
                sden = r_den[k-1];
                ssb  = r_sb[k-1];
                sv   = r_v[k-1];
            end
        end

        always_comb begin
            tmp = {srem, snq[NW-1]};
            ge  = tmp >= {1'b0, sden};
            dif = tmp - {1'b0, sden};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= sv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k]  <= {snq[NW-2:0], ge};
                r_rem[k] <= ge ? dif[DW-1:0] : tmp[DW-1:0];
                r_den[k] <= sden;
                r_sb[k]  <= ssb;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_q     = r_nq[NW-1];
    assign o_sb    = r_sb[NW-1];
endmodule
`default_nettype wire

/* src/spar_pos.sv */
// spar_pos: shape factor clamp, strip term, width product, rounding and
// saturation; three register stages, the last is the output register.
// Depends on spar_pkg.
`default_nettype none
module spar_pos (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_en,
    input  wire                                    i_valid,
    input  wire [spar_pkg::NUM_W-1:0]              i_q,
    input  wire                                    i_neg,
    input  spar_pkg::t_meta                        i_meta,
    input  wire [spar_pkg::CFG_W-1:0]              i_center,
    input  wire [spar_pkg::CFG_W-1:0]              i_width,
    input  wire signed [spar_pkg::OFS_W-1:0]       i_offset,
    input  wire                                    i_turned,
    output logic                                   o_valid,
    output spar_pkg::t_out                         o_data
);
    localparam int TW    = spar_pkg::T_W;
    localparam int PW    = spar_pkg::P_W;
    localparam int SW    = PW + 1;
    localparam int QW    = SW - spar_pkg::STRIP_SHIFT;
    localparam int QT_W  = QW + 1;
    localparam int PO_W  = spar_pkg::POS_W;
    localparam logic signed [QT_W-1:0] SAT_HI = QT_W'((64'sd1 <<< (PO_W - 1)) - 1);
    localparam logic signed [QT_W-1:0] SAT_LO = -SAT_HI - QT_W'(1);
    localparam logic signed [SW-1:0]   RND    = SW'(1) <<< (spar_pkg::STRIP_SHIFT - 1);

    // stage 1
    logic [spar_pkg::K_BITS-1:0]   kmag;
    logic signed [spar_pkg::K_W-1:0] k_s;
    logic signed [TW-1:0]          t_n;
    logic                          r1_v;
    logic signed [TW-1:0]          r1_t;
    spar_pkg::t_meta               r1_meta;
    // stage 2
    logic                          r2_v;
    logic signed [PW-1:0]          r2_p;
    spar_pkg::t_meta               r2_meta;
    // stage 3
    logic signed [SW-1:0]          s;
    logic signed [QW-1:0]          qv;
    logic signed [QT_W-1:0]        qt;
    logic signed [PO_W-1:0]        pos;
    spar_pkg::t_out                n_out;

    always_comb begin
        kmag = (i_q > spar_pkg::K_LIMIT) ? spar_pkg::K_LIMIT[spar_pkg::K_BITS-1:0]
                                         : i_q[spar_pkg::K_BITS-1:0];
        // sign of atan quotient, then flipped again unless id0 < id1
        k_s  = (i_neg ^ !i_meta.dir_pos) ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
        t_n  = ($signed({{(TW - spar_pkg::ID_W){1'b0}}, i_meta.id0}) <<< spar_pkg::STRIP_SHIFT)
             - ($signed({{(TW - spar_pkg::CFG_W){1'b0}}, i_center}) <<< spar_pkg::CENTER_SHIFT)
             + TW'(k_s);
    end

    always_comb begin
        s   = SW'(r2_p) - (SW'(i_offset) <<< spar_pkg::STRIP_SHIFT) + RND;
        qv  = s[SW-1:spar_pkg::STRIP_SHIFT];
        qt  = i_turned ? -QT_W'(qv) : QT_W'(qv);
        if (qt > SAT_HI) begin
            pos = SAT_HI[PO_W-1:0];
        end else if (qt < SAT_LO) begin
            pos = SAT_LO[PO_W-1:0];
        end else begin
            pos = qt[PO_W-1:0];
        end
        n_out.valid_res   = r2_meta.ok;
        n_out.hit_strip   = r2_meta.ok ? r2_meta.id0 : '0;
        n_out.hit_charge  = r2_meta.ok ? r2_meta.c0 : '0;
        n_out.position_mm = r2_meta.ok ? pos : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            o_valid <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_t    <= t_n;
            r1_meta <= i_meta;
            r2_p    <= r1_t * $signed({1'b0, i_width});
            r2_meta <= r1_meta;
            o_data  <= n_out;
        end
    end
endmodule
`default_nettype wire

/* src/strip_position_atan_ratio_top.sv */
// strip_position_atan_ratio_top: strip position by charge-ratio arctangent.
// Depends on spar_pkg, spar_front, spar_cordic, spar_div, spar_pos.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------
//  event   | in        | i_valid / o_ready  | i_data  (spar_pkg::t_in)
//  result  | out       | o_valid / i_ready  | o_data  (spar_pkg::t_out)
//  config  | in        | APB psel/penable   | paddr, pwdata, prdata
//
// One event transaction per clock while o_ready is high; every event yields exactly one result.
// Pipeline order: front checks, ratio CORDIC, angle/multiply stage, shape
// CORDIC pair, quotient divider (one bit per stage) and position, the last
// register of which is the output register.
// Reset is synchronous, active low; it clears the valid bits and sets the
// configuration registers to their reset values (r_shape_b to 256, the rest to zero).
// A stalled result freezes the whole pipe; the entry stage still takes a
// transaction while it is empty, so nothing is dropped or repeated.
`default_nettype none
module strip_position_atan_ratio_top #(
    parameter int ATAN_ITERATIONS = spar_pkg::ATAN_ITER_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // event transactions
    input  wire                          i_valid,
    output logic                         o_ready,
    input  spar_pkg::t_in                i_data,
    // result transactions
    output logic                         o_valid,
    input  wire                          i_ready,
    output spar_pkg::t_out               o_data,
    // configuration
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [spar_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    localparam int CW      = spar_pkg::CORDIC_W;
    localparam int ZW      = spar_pkg::ANG_W;
    localparam int MW      = $bits(spar_pkg::t_meta);
    localparam int SB1_W   = MW + 2;
    localparam int SB3_W   = MW + 1;

    // ---------------- configuration registers ----------------
    logic [spar_pkg::CFG_W-1:0]        r_shape_b, r_center, r_width;
    logic signed [spar_pkg::OFS_W-1:0] r_offset;
    logic                              r_turned;
    logic                              wr;
    logic [2:0]                        widx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = paddr[spar_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_b <= spar_pkg::RST_SHAPE_B;
            r_center  <= '0;
            r_width   <= '0;
            r_offset  <= '0;
            r_turned  <= 1'b0;
        end else if (wr) begin
            unique case (widx)
                spar_pkg::REG_SHAPE_B: r_shape_b <= pwdata[spar_pkg::CFG_W-1:0];
                spar_pkg::REG_CENTER:  r_center  <= pwdata[spar_pkg::CFG_W-1:0];
                spar_pkg::REG_WIDTH:   r_width   <= pwdata[spar_pkg::CFG_W-1:0];
                spar_pkg::REG_OFFSET:  r_offset  <= pwdata[spar_pkg::OFS_W-1:0];
                spar_pkg::REG_TURNED:  r_turned  <= pwdata[0];
                default: ;                          // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            spar_pkg::REG_SHAPE_B: prdata = {16'b0, r_shape_b};
            spar_pkg::REG_CENTER:  prdata = {16'b0, r_center};
            spar_pkg::REG_WIDTH:   prdata = {16'b0, r_width};
            spar_pkg::REG_OFFSET:  prdata = {{8{r_offset[spar_pkg::OFS_W-1]}}, r_offset};
            spar_pkg::REG_TURNED:  prdata = {31'b0, r_turned};
            default:               prdata = '0;
        endcase
    end

    // ---------------- pipeline flow control ----------------
    // adv moves every stage; the front stage may also fill while empty
    logic adv, front_en;
    logic front_v;
    logic pos_v;

    assign adv      = !pos_v || i_ready;
    assign front_en = adv || !front_v;
    assign o_ready  = front_en;
    assign o_valid  = pos_v;

    // ---------------- front: checks and ratio operands ----------------
    spar_pkg::t_meta      front_meta;
    logic                 front_byp, front_byp_neg;
    logic signed [CW-1:0] front_x, front_y;

    spar_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (front_en),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .i_b_nz    (r_shape_b != '0),
        .o_valid   (front_v),
        .o_meta    (front_meta),
        .o_bypass  (front_byp),
        .o_byp_neg (front_byp_neg),
        .o_x       (front_x),
        .o_y       (front_y)
    );

    // ---------------- alpha = atan(yr/xr) ----------------
    logic signed [CW-1:0] c1_x [1];
    logic signed [CW-1:0] c1_y [1];
    logic signed [ZW-1:0] c1_z [1];
    logic [SB1_W-1:0]     c1_sb;
    logic                 c1_v;

    assign c1_x[0] = front_x;
    assign c1_y[0] = front_y;

    spar_cordic #(
        .ITER  (ATAN_ITERATIONS),
        .LANES (1),
        .SB_W  (SB1_W)
    ) u_cordic_alpha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (front_v),
        .i_x     (c1_x),
        .i_y     (c1_y),
        .i_sb    ({front_byp, front_byp_neg, front_meta}),
        .o_valid (c1_v),
        .o_z     (c1_z),
        .o_sb    (c1_sb)
    );

    // ---------------- angle stage: b*(alpha-pi/4) and b*pi/4 ----------------
    logic signed [ZW-1:0] alpha;
    logic signed [ZW:0]   diff;
    logic signed [ZW+spar_pkg::CFG_W+1:0] shape_diff, shape_pi4;
    logic                 r_a_v;
    logic signed [CW-1:0] r_a_y [2];
    spar_pkg::t_meta      r_a_meta;

    always_comb begin
        // xr == 0: alpha is +-pi/2 by the sign of the numerator
        if (c1_sb[SB1_W-1]) begin
            alpha = c1_sb[SB1_W-2] ? -spar_pkg::PI2 : spar_pkg::PI2;
        end else begin
            alpha = c1_z[0];
        end
        diff       = (ZW+1)'(alpha) - (ZW+1)'(spar_pkg::PI4);
        shape_diff = $signed({1'b0, r_shape_b}) * diff;
        shape_pi4  = $signed({1'b0, r_shape_b}) * spar_pkg::PI4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (adv) begin
            r_a_v <= c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_y[0] <= CW'(shape_diff);
            r_a_y[1] <= CW'(shape_pi4);
            r_a_meta <= spar_pkg::t_meta'(c1_sb[MW-1:0]);
        end
    end

    // ---------------- ka and kd CORDIC pair ----------------
    logic signed [CW-1:0] c2_x [2];
    logic signed [ZW-1:0] c2_z [2];
    logic [MW-1:0]        c2_sb;
    logic                 c2_v;

    assign c2_x[0] = spar_pkg::ONE_Q32;
    assign c2_x[1] = spar_pkg::ONE_Q32;

    spar_cordic #(
        .ITER  (ATAN_ITERATIONS),
        .LANES (2),
        .SB_W  (MW)
    ) u_cordic_shape (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_a_v),
        .i_x     (c2_x),
        .i_y     (r_a_y),
        .i_sb    (r_a_meta),
        .o_valid (c2_v),
        .o_z     (c2_z),
        .o_sb    (c2_sb)
    );

    // ---------------- k = ka * 2^24 / kd ----------------
    logic                           ka_neg;
    logic signed [ZW-1:0]           ka_abs;
    spar_pkg::t_meta                d_meta;
    logic [spar_pkg::NUM_W-1:0]     div_q;
    logic [SB3_W-1:0]               div_sb;
    logic                           div_v;

    always_comb begin
        ka_neg    = c2_z[0][ZW-1];
        ka_abs    = ka_neg ? -c2_z[0] : c2_z[0];
        d_meta    = spar_pkg::t_meta'(c2_sb);
        // a normalizing angle that is not positive makes the event invalid
        d_meta.ok = d_meta.ok && !c2_z[1][ZW-1] && (c2_z[1] != '0);
    end

    spar_div #(
        .NW   (spar_pkg::NUM_W),
        .DW   (spar_pkg::DEN_W),
        .SB_W (SB3_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (c2_v),
        .i_num   ({ka_abs[ZW-2:0], {spar_pkg::FRAC{1'b0}}, 1'b0} >> 1),
        .i_den   (c2_z[1][ZW-2:0]),
        .i_sb    ({ka_neg, d_meta}),
        .o_valid (div_v),
        .o_q     (div_q),
        .o_sb    (div_sb)
    );

    // ---------------- position and output register ----------------
    spar_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (div_v),
        .i_q      (div_q),
        .i_neg    (div_sb[SB3_W-1]),
        .i_meta   (spar_pkg::t_meta'(div_sb[MW-1:0])),
        .i_center (r_center),
        .i_width  (r_width),
        .i_offset (r_offset),
        .i_turned (r_turned),
        .o_valid  (pos_v),
        .o_data   (o_data)
    );

    // ---------------- assertions ----------------
    // a rejected event carries all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.valid_res) |->
            (o_data.position_mm == '0 && o_data.hit_strip == '0 && o_data.hit_charge == '0))
        else $error("invalid result with nonzero fields");

    // an accepted result always had a nonzero leading charge
    a_valid_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.valid_res) |-> (o_data.hit_charge != '0))
        else $error("valid result with zero leading charge");

    // while the output is stalled, only an empty entry stage may take an event
    a_stall_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && i_valid && o_ready) |-> !front_v)
        else $error("event taken into an occupied entry stage during stall");

    // a stalled pipe keeps its output register occupied
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result vanished while stalled");
endmodule
`default_nettype wire
